// File: rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and tone sequence tables for the buzzer pattern
// sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_START    = 2'd1,
    ACT_STOP     = 2'd2,
    ACT_SET_FREQ = 2'd3
  } action_e;

  localparam logic [3:0] MODE_OFF     = 4'd0;
  localparam logic [3:0] MODE_CONT    = 4'd1;
  localparam logic [3:0] MODE_FAST    = 4'd2;
  localparam logic [3:0] MODE_SLOW    = 4'd3;
  localparam logic [3:0] MODE_PULSE   = 4'd4;
  localparam logic [3:0] MODE_ALARM   = 4'd5;
  localparam logic [3:0] MODE_SUCCESS = 4'd6;
  localparam logic [3:0] MODE_ERROR   = 4'd7;
  localparam logic [3:0] MODE_NOTIF   = 4'd8;

  localparam logic [1:0] REG_FAST_HALF  = 2'd0;
  localparam logic [1:0] REG_SLOW_HALF  = 2'd1;
  localparam logic [1:0] REG_PULSE_INTV = 2'd2;

  localparam logic [15:0] FAST_HALF_RST  = 16'd250;
  localparam logic [15:0] SLOW_HALF_RST  = 16'd1000;
  localparam logic [15:0] PULSE_INTV_RST = 16'd100;
  localparam logic [15:0] DEFAULT_FREQ   = 16'd2000;
  localparam logic [7:0]  TONE_DUTY      = 8'd128;
  localparam logic [7:0]  PULSE_STEP     = 8'd32;
  localparam logic [7:0]  PULSE_MAX      = 8'd255;
  localparam logic [2:0]  STEP_MAX       = 3'd4;

  typedef struct packed {
    action_e     action;
    logic [3:0]  pattern_code;
    logic [15:0] frequency_hz;
  } bps_in_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic [15:0] tone_frequency_hz;
    logic        active;
  } bps_out_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } bps_buf_stat_t;

  function automatic logic [15:0] rom_freq(input logic [3:0] e);
    logic [15:0] r;
    case (e)
      4'd0:    r = 16'd2000;
      4'd1:    r = 16'd2500;
      4'd2:    r = 16'd2000;
      4'd3:    r = 16'd2500;
      4'd4:    r = 16'd1000;
      4'd5:    r = 16'd1500;
      4'd6:    r = 16'd2000;
      4'd7:    r = 16'd500;
      4'd8:    r = 16'd400;
      4'd9:    r = 16'd300;
      4'd10:   r = 16'd1500;
      4'd11:   r = 16'd1500;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rom_dur(input logic [3:0] e);
    logic [15:0] r;
    case (e)
      4'd0:    r = 16'd500;
      4'd1:    r = 16'd500;
      4'd2:    r = 16'd500;
      4'd3:    r = 16'd500;
      4'd4:    r = 16'd100;
      4'd5:    r = 16'd100;
      4'd6:    r = 16'd200;
      4'd7:    r = 16'd300;
      4'd8:    r = 16'd300;
      4'd9:    r = 16'd500;
      4'd10:   r = 16'd200;
      4'd11:   r = 16'd200;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rom_pause(input logic [3:0] e);
    logic [15:0] r;
    case (e)
      4'd0:    r = 16'd200;
      4'd1:    r = 16'd200;
      4'd2:    r = 16'd200;
      4'd3:    r = 16'd1000;
      4'd4:    r = 16'd50;
      4'd5:    r = 16'd50;
      4'd6:    r = 16'd0;
      4'd7:    r = 16'd100;
      4'd8:    r = 16'd100;
      4'd9:    r = 16'd0;
      4'd10:   r = 16'd200;
      4'd11:   r = 16'd0;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] seq_base(input logic [1:0] s);
    logic [3:0] r;
    case (s)
      2'd0:    r = 4'd0;
      2'd1:    r = 4'd4;
      2'd2:    r = 4'd7;
      2'd3:    r = 4'd10;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] seq_len(input logic [1:0] s);
    logic [2:0] r;
    case (s)
      2'd0:    r = 3'd4;
      2'd1:    r = 3'd3;
      2'd2:    r = 3'd3;
      2'd3:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/bps_core.sv
// ----------------------------------------------------------------------------
// bps_core
// Pattern state, configuration registers and the single-pass update that
// turns one registered item into the next state and its result.
// ----------------------------------------------------------------------------
module bps_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              proc_valid_i,
  input  bps_pkg::bps_in_t  proc_item_i,
  output bps_pkg::bps_out_t res_o
);
  import bps_pkg::*;

  logic [15:0] fast_half_q, slow_half_q, pulse_intv_q;

  logic [3:0]  mode_q, mode_d;
  logic        running_q, running_d;
  logic        tone_on_q, tone_on_d;
  logic        pause_q, pause_d;
  logic [2:0]  step_q, step_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] freq_q, freq_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  intens_q, intens_d;
  logic        falling_q, falling_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_half_q  <= FAST_HALF_RST;
      slow_half_q  <= SLOW_HALF_RST;
      pulse_intv_q <= PULSE_INTV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FAST_HALF:  fast_half_q  <= cfg_wdata_i;
        REG_SLOW_HALF:  slow_half_q  <= cfg_wdata_i;
        REG_PULSE_INTV: pulse_intv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] el;
    logic [15:0] half;
    logic [1:0]  s;
    logic [3:0]  mrel;
    logic [2:0]  len;
    logic [3:0]  e;
    logic [8:0]  v;

    mode_d    = mode_q;
    running_d = running_q;
    tone_on_d = tone_on_q;
    pause_d   = pause_q;
    step_d    = step_q;
    elapsed_d = elapsed_q;
    freq_d    = freq_q;
    duty_d    = duty_q;
    intens_d  = intens_q;
    falling_d = falling_q;

    el   = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
    half = (mode_q == MODE_FAST) ? fast_half_q : slow_half_q;
    mrel = mode_q - MODE_ALARM;
    s    = mrel[1:0];
    len  = seq_len(s);
    e    = seq_base(s) + ((step_q < len) ? {1'b0, step_q} : 4'd0);
    v    = {1'b0, intens_q} + {1'b0, PULSE_STEP};

    case (proc_item_i.action)
      ACT_TICK: begin
        elapsed_d = el;
        case (mode_q)
          MODE_FAST, MODE_SLOW: begin
            if (el >= half) begin
              tone_on_d = !tone_on_q;
              duty_d    = tone_on_q ? 8'd0 : TONE_DUTY;
              elapsed_d = 16'd0;
            end
          end
          MODE_PULSE: begin
            if (el >= pulse_intv_q) begin
              if (!falling_q) begin
                if (v >= {1'b0, PULSE_MAX}) begin
                  intens_d  = PULSE_MAX;
                  falling_d = 1'b1;
                end else begin
                  intens_d = v[7:0];
                end
              end else if (intens_q <= PULSE_STEP) begin
                intens_d  = 8'd0;
                falling_d = 1'b0;
              end else begin
                intens_d = intens_q - PULSE_STEP;
              end
              duty_d    = intens_d;
              elapsed_d = 16'd0;
            end
          end
          MODE_ALARM, MODE_SUCCESS, MODE_ERROR, MODE_NOTIF: begin
            if (!tone_on_q) begin
              if (pause_q) begin
                if (el >= rom_pause(e)) begin
                  pause_d = 1'b0;
                  step_d  = step_q + 3'd1;
                end
              end else if (step_q < len) begin
                freq_d    = rom_freq(e);
                duty_d    = TONE_DUTY;
                tone_on_d = 1'b1;
                elapsed_d = 16'd0;
              end else if (mode_q == MODE_ALARM) begin
                step_d = 3'd0;
              end else begin
                mode_d    = MODE_OFF;
                duty_d    = 8'd0;
                running_d = 1'b0;
              end
            end else if (el >= rom_dur(e)) begin
              duty_d    = 8'd0;
              tone_on_d = 1'b0;
              elapsed_d = 16'd0;
              if (rom_pause(e) != 16'd0) begin
                pause_d = 1'b1;
              end else begin
                step_d = step_q + 3'd1;
              end
            end
          end
          default: ;
        endcase
      end
      ACT_START: begin
        elapsed_d = 16'd0;
        step_d    = 3'd0;
        tone_on_d = 1'b0;
        pause_d   = 1'b0;
        if (proc_item_i.pattern_code > MODE_NOTIF ||
            proc_item_i.pattern_code == MODE_OFF) begin
          mode_d    = MODE_OFF;
          duty_d    = 8'd0;
          running_d = 1'b0;
        end else begin
          mode_d    = proc_item_i.pattern_code;
          running_d = 1'b1;
          if (proc_item_i.pattern_code == MODE_CONT) begin
            duty_d = TONE_DUTY;
          end else if (proc_item_i.pattern_code >= MODE_ALARM) begin
            mrel      = proc_item_i.pattern_code - MODE_ALARM;
            freq_d    = rom_freq(seq_base(mrel[1:0]));
            duty_d    = TONE_DUTY;
            tone_on_d = 1'b1;
          end
        end
      end
      ACT_STOP: begin
        mode_d    = MODE_OFF;
        duty_d    = 8'd0;
        running_d = 1'b0;
      end
      ACT_SET_FREQ: begin
        if (proc_item_i.frequency_hz != 16'd0) begin
          freq_d = proc_item_i.frequency_hz;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      running_q <= 1'b0;
      tone_on_q <= 1'b0;
      pause_q   <= 1'b0;
      step_q    <= 3'd0;
      elapsed_q <= 16'd0;
      freq_q    <= DEFAULT_FREQ;
      duty_q    <= 8'd0;
      intens_q  <= 8'd0;
      falling_q <= 1'b0;
    end else if (proc_valid_i) begin
      mode_q    <= mode_d;
      running_q <= running_d;
      tone_on_q <= tone_on_d;
      pause_q   <= pause_d;
      step_q    <= step_d;
      elapsed_q <= elapsed_d;
      freq_q    <= freq_d;
      duty_q    <= duty_d;
      intens_q  <= intens_d;
      falling_q <= falling_d;
    end
  end

  assign res_o.duty              = duty_d;
  assign res_o.tone_frequency_hz = freq_d;
  assign res_o.active            = running_d;

  a_run_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q == (mode_q != MODE_OFF))
    else $error("running flag disagrees with pattern mode");

  a_tone_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tone_on_q && pause_q))
    else $error("tone and pause phase both set");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_MAX)
    else $error("sequence step beyond longest sequence");

endmodule

// File: rtl/bps_out_buf.sv
// ----------------------------------------------------------------------------
// bps_out_buf
// Result register with a skid stage, so a stalled result does not block
// the update of the next item.
// ----------------------------------------------------------------------------
module bps_out_buf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   proc_valid_i,
  input  bps_pkg::bps_out_t      proc_item_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output bps_pkg::bps_out_t      out_item_o,
  output bps_pkg::bps_buf_stat_t stat_o
);
  import bps_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  bps_out_t out_item_q, out_item_d;
  bps_out_t skid_item_q, skid_item_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_item_d   = out_item_q;
    skid_item_d  = skid_item_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_item_d   = skid_item_q;
        skid_valid_d = proc_valid_i;
        skid_item_d  = proc_item_i;
      end else begin
        out_valid_d = proc_valid_i;
        out_item_d  = proc_item_i;
      end
    end else if (proc_valid_i) begin
      skid_valid_d = 1'b1;
      skid_item_d  = proc_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q  <= out_item_d;
    skid_item_q <= skid_item_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;
  assign stat_o.out_valid  = out_valid_q;
  assign stat_o.skid_valid = skid_valid_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while result register is empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_valid_i && skid_valid_q) |-> !out_stall_i)
    else $error("item arrives with both result stages full");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_item_q)))
    else $error("stalled result changed or dropped");

endmodule

// File: rtl/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Buzzer tone pattern sequencer: ticks, starts, stops and frequency changes
// in, one duty / frequency / active result out for each item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_stall_o  in_item_i   (bps_in_t)
//  out      output     out_valid_o / out_stall_i out_item_o (bps_out_t)
//  cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
//  One item per cycle while in_stall_o is low; the item is registered at its
//  accepting edge and its result in the result register, which raises
//  out_valid_o and holds the result until it is taken.
//  Reset clears the pattern state and loads the default periods and frequency.
//  A stalled result holds in the result register; the item behind it drops
//  into the skid stage, and in_stall_o is high while that move is due or
//  the skid stage is full.
// ----------------------------------------------------------------------------
module buzzer_pattern_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bps_pkg::bps_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bps_pkg::bps_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import bps_pkg::*;

  logic          ir_valid_q;
  bps_in_t       ir_item_q;
  bps_out_t      res;
  bps_buf_stat_t stat;
  logic          in_accept;

  assign in_stall_o = stat.skid_valid || (stat.out_valid && ir_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_valid_q <= 1'b0;
    end else begin
      ir_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ir_item_q <= in_item_i;
    end
  end

  bps_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .proc_valid_i (ir_valid_q),
    .proc_item_i  (ir_item_q),
    .res_o        (res)
  );

  bps_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .proc_valid_i (ir_valid_q),
    .proc_item_i  (res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .stat_o       (stat)
  );

endmodule

// File: verif/buzzer_pattern_sequencer_checker.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_checker
// Watches the item, result and register ports of the buzzer sequencer. It
// keeps its own copy of the pattern state and period registers, works out
// the duty, frequency and active flag that each accepted item must give,
// and compares every accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  bps_pkg::bps_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  bps_pkg::bps_out_t out_item_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  import bps_pkg::*;

  // tone table, entry 11 first
  localparam logic [11:0][15:0] STEP_HZ = {
    16'd1500, 16'd1500, 16'd300,  16'd400,  16'd500,  16'd2000,
    16'd1500, 16'd1000, 16'd2500, 16'd2000, 16'd2500, 16'd2000
  };
  localparam logic [11:0][15:0] STEP_ON_MS = {
    16'd200, 16'd200, 16'd500, 16'd300, 16'd300, 16'd200,
    16'd100, 16'd100, 16'd500, 16'd500, 16'd500, 16'd500
  };
  localparam logic [11:0][15:0] STEP_GAP_MS = {
    16'd0,   16'd200, 16'd0,   16'd100,  16'd100, 16'd0,
    16'd50,  16'd50,  16'd1000, 16'd200, 16'd200, 16'd200
  };
  localparam logic [3:0][3:0] SEQ_FIRST = {4'd10, 4'd7, 4'd4, 4'd0};
  localparam logic [3:0][2:0] SEQ_STEPS = {3'd2, 3'd3, 3'd3, 3'd4};

  logic [15:0] fast_ms, slow_ms, ramp_ms;
  logic [3:0]  pat_mode;
  logic        playing, tone_on, in_gap, ramp_down;
  logic [2:0]  step_no;
  logic [15:0] ms_count, cur_hz;
  logic [7:0]  cur_duty, ramp_level;

  bps_out_t    due_pwm[$];
  bps_out_t    want;

  task automatic silence();
    pat_mode = MODE_OFF;
    cur_duty = '0;
    playing  = 1'b0;
  endtask

  task automatic seq_tick();
    logic [3:0] d;
    logic [1:0] s;
    logic [2:0] n;
    logic [3:0] e;
    d = pat_mode - MODE_ALARM;
    s = d[1:0];
    n = SEQ_STEPS[s];
    e = SEQ_FIRST[s] + ((step_no < n) ? {1'b0, step_no} : 4'd0);
    if (!tone_on) begin
      if (in_gap) begin
        if (ms_count >= STEP_GAP_MS[e]) begin
          in_gap  = 1'b0;
          step_no = step_no + 3'd1;
        end
      end else if (step_no < n) begin
        cur_hz   = STEP_HZ[e];
        cur_duty = TONE_DUTY;
        tone_on  = 1'b1;
        ms_count = '0;
      end else if (pat_mode == MODE_ALARM) begin
        step_no = '0;
      end else begin
        silence();
      end
    end else if (ms_count >= STEP_ON_MS[e]) begin
      cur_duty = '0;
      tone_on  = 1'b0;
      ms_count = '0;
      if (STEP_GAP_MS[e] != 16'd0) in_gap = 1'b1;
      else step_no = step_no + 3'd1;
    end
  endtask

  task automatic toggle_tick(input logic [15:0] half_ms);
    if (ms_count >= half_ms) begin
      tone_on  = !tone_on;
      cur_duty = tone_on ? TONE_DUTY : 8'd0;
      ms_count = '0;
    end
  endtask

  task automatic ramp_tick();
    logic [8:0] lvl;
    if (ms_count >= ramp_ms) begin
      if (!ramp_down) begin
        lvl = {1'b0, ramp_level} + {1'b0, PULSE_STEP};
        if (lvl >= {1'b0, PULSE_MAX}) begin
          lvl       = {1'b0, PULSE_MAX};
          ramp_down = 1'b1;
        end
        ramp_level = lvl[7:0];
      end else if (ramp_level <= PULSE_STEP) begin
        ramp_level = '0;
        ramp_down  = 1'b0;
      end else begin
        ramp_level = ramp_level - PULSE_STEP;
      end
      cur_duty = ramp_level;
      ms_count = '0;
    end
  endtask

  task automatic start_pattern(input logic [3:0] code);
    ms_count = '0;
    step_no  = '0;
    tone_on  = 1'b0;
    in_gap   = 1'b0;
    if (code > MODE_NOTIF || code == MODE_OFF) begin
      silence();
    end else begin
      pat_mode = code;
      playing  = 1'b1;
      if (code == MODE_CONT) cur_duty = TONE_DUTY;
      else if (code >= MODE_ALARM) seq_tick();
    end
  endtask

  task automatic apply_item(input bps_in_t it);
    case (it.action)
      ACT_TICK: begin
        if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
        if (pat_mode == MODE_FAST) toggle_tick(fast_ms);
        else if (pat_mode == MODE_SLOW) toggle_tick(slow_ms);
        else if (pat_mode == MODE_PULSE) ramp_tick();
        else if (pat_mode >= MODE_ALARM && pat_mode <= MODE_NOTIF) seq_tick();
      end
      ACT_START: start_pattern(it.pattern_code);
      ACT_STOP: silence();
      default: begin
        if (it.frequency_hz != 16'd0) cur_hz = it.frequency_hz;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_ms      = FAST_HALF_RST;
      slow_ms      = SLOW_HALF_RST;
      ramp_ms      = PULSE_INTV_RST;
      pat_mode     = MODE_OFF;
      playing      = 1'b0;
      tone_on      = 1'b0;
      in_gap       = 1'b0;
      step_no      = '0;
      ms_count     = '0;
      cur_hz       = DEFAULT_FREQ;
      cur_duty     = '0;
      ramp_level   = '0;
      ramp_down    = 1'b0;
      due_pwm.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (due_pwm.size() == 0) begin
          $error("result with no item pending: duty %0d freq %0d active %0d",
                 out_item_i.duty, out_item_i.tone_frequency_hz, out_item_i.active);
          fail_count_o++;
        end else begin
          want = due_pwm.pop_front();
          if (out_item_i.duty !== want.duty) begin
            $error("duty: expected %0d, actual %0d", want.duty, out_item_i.duty);
            fail_count_o++;
          end
          if (out_item_i.tone_frequency_hz !== want.tone_frequency_hz) begin
            $error("tone_frequency_hz: expected %0d, actual %0d",
                   want.tone_frequency_hz, out_item_i.tone_frequency_hz);
            fail_count_o++;
          end
          if (out_item_i.active !== want.active) begin
            $error("active: expected %0d, actual %0d", want.active, out_item_i.active);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FAST_HALF:  fast_ms = cfg_wdata_i;
          REG_SLOW_HALF:  slow_ms = cfg_wdata_i;
          REG_PULSE_INTV: ramp_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        apply_item(in_item_i);
        want.duty              = cur_duty;
        want.tone_frequency_hz = cur_hz;
        want.active            = playing;
        due_pwm.push_back(want);
      end
      pending_o = due_pwm.size();
    end
  end

endmodule

// File: verif/buzzer_pattern_sequencer_tb.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer_tb
// Drives ticks, pattern starts, stops and frequency requests into the buzzer
// sequencer under three idling regimes, reprograms the period registers
// between bursts, and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_pattern_sequencer_tb;
  import bps_pkg::*;

  localparam logic [3:0]  PAT_BAD_LO  = 4'd9;
  localparam logic [3:0]  PAT_LAST    = 4'd15;
  localparam logic [1:0]  REG_NONE    = 2'd3;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  bps_in_t     in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bps_out_t    out_item;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  int          fail_count;
  int          pending;
  int          checked;
  int          in_idle_pct;
  int          out_stall_pct;
  int unsigned n_sent;
  int unsigned n_settings;
  int unsigned cycle_count = 0;

  buzzer_pattern_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  buzzer_pattern_sequencer_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] rand_hz();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'd1;
    if (r == 3) return 16'($urandom);
    return 16'($urandom_range(1, 40000));
  endfunction

  function automatic logic [15:0] pick_period(input logic [15:0] rst_val);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd1;
    if (r == 2) return 16'hFFFF;
    if (r == 3) return rst_val;
    return 16'($urandom_range(1, 40));
  endfunction

  task automatic send_item(input action_e act, input logic [3:0] code,
                           input logic [15:0] hz);
    bps_in_t it;
    it.action       = act;
    it.pattern_code = code;
    it.frequency_hz = hz;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] fast_ms, input logic [15:0] slow_ms,
                              input logic [15:0] ramp_ms);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FAST_HALF;
    cfg_wdata <= fast_ms;
    @(posedge clk_i);
    cfg_idx   <= REG_SLOW_HALF;
    cfg_wdata <= slow_ms;
    @(posedge clk_i);
    cfg_idx   <= REG_PULSE_INTV;
    cfg_wdata <= ramp_ms;
    @(posedge clk_i);
    cfg_idx   <= REG_NONE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic run_burst(input logic [3:0] code, input int unsigned len,
                           input bit noisy);
    int unsigned k;
    int unsigned r;
    send_item(ACT_START, code, rand_hz());
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 199);
      if (r < 184) send_item(ACT_TICK, 4'($urandom), 16'($urandom));
      else if (r < 194 || !noisy) send_item(ACT_SET_FREQ, 4'($urandom), rand_hz());
      else if (r < 197) send_item(ACT_START, 4'($urandom), 16'($urandom));
      else send_item(ACT_STOP, 4'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_bursts();
    int unsigned first;
    int unsigned r;
    logic [3:0]  code;
    int unsigned len;
    first = n_sent;
    while (n_sent - first < PHASE_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        program_regs(pick_period(FAST_HALF_RST), pick_period(SLOW_HALF_RST),
                     pick_period(PULSE_INTV_RST));
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        code = ($urandom_range(0, 1) == 0) ? MODE_CONT : MODE_OFF;
        len  = $urandom_range(1, 12);
      end else if (r < 55) begin
        code = 4'($urandom_range(MODE_FAST, MODE_PULSE));
        len  = $urandom_range(5, 150);
      end else if (r < 85) begin
        code = 4'($urandom_range(MODE_ALARM, MODE_NOTIF));
        len  = $urandom_range(40, 250);
      end else begin
        code = 4'($urandom_range(PAT_BAD_LO, PAT_LAST));
        len  = $urandom_range(1, 12);
      end
      run_burst(code, len, 1'b1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_FAST_HALF;
    cfg_wdata     = '0;
    in_idle_pct   = 7;
    out_stall_pct = 83;
    n_sent        = 0;
    n_settings    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_TICK, MODE_OFF, 16'd0);
    send_item(ACT_SET_FREQ, MODE_OFF, 16'd0);
    send_item(ACT_SET_FREQ, MODE_OFF, 16'hFFFF);
    send_item(ACT_SET_FREQ, PAT_LAST, 16'd1);
    send_item(ACT_START, MODE_CONT, 16'hFFFF);
    send_item(ACT_TICK, PAT_LAST, 16'hFFFF);
    send_item(ACT_START, PAT_LAST, 16'd0);
    send_item(ACT_SET_FREQ, MODE_OFF, 16'd40000);
    send_item(ACT_START, MODE_CONT, 16'd0);
    send_item(ACT_START, MODE_FAST, 16'd0);
    send_item(ACT_TICK, MODE_OFF, 16'd0);
    send_item(ACT_START, MODE_SLOW, 16'd0);
    send_item(ACT_START, MODE_PULSE, 16'd0);
    send_item(ACT_TICK, MODE_OFF, 16'd0);
    send_item(ACT_START, PAT_BAD_LO, 16'd0);
    send_item(ACT_START, MODE_ALARM, 16'd0);
    send_item(ACT_TICK, MODE_OFF, 16'd0);
    send_item(ACT_SET_FREQ, MODE_OFF, 16'd2);
    send_item(ACT_START, MODE_SUCCESS, 16'd0);
    send_item(ACT_START, MODE_ERROR, 16'd0);
    send_item(ACT_START, MODE_NOTIF, 16'd0);
    send_item(ACT_STOP, PAT_LAST, 16'hFFFF);
    send_item(ACT_START, MODE_OFF, 16'd0);
    send_item(ACT_TICK, MODE_OFF, 16'd0);
    send_item(ACT_SET_FREQ, MODE_OFF, DEFAULT_FREQ);

    run_burst(MODE_FAST, 100, 1'b0);
    random_bursts();

    settle();
    in_idle_pct   = 83;
    out_stall_pct = 7;
    program_regs(16'd0, 16'd0, 16'd0);
    run_burst(MODE_FAST, 20, 1'b0);
    run_burst(MODE_SLOW, 20, 1'b0);
    run_burst(MODE_PULSE, 40, 1'b0);
    run_burst(MODE_ERROR, 150, 1'b0);
    random_bursts();

    settle();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    program_regs(16'd1, 16'hFFFF, 16'd1);
    run_burst(MODE_PULSE, 40, 1'b0);
    run_burst(MODE_SUCCESS, 600, 1'b0);
    run_burst(MODE_NOTIF, 200, 1'b0);

    settle();
    $display("Covered %0d items and %0d results under three idling regimes,",
             n_sent, checked);
    $display("with %0d period register settings including zero and full scale.",
             n_settings);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
